>>> src/asdx_pkg.sv
// Shared types, character codes and result codes for the sentence decoder.
package asdx_pkg;

    localparam logic [7:0] FRAME_MAX = 8'd64;

    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;

    localparam logic [7:0] DEC_RADIX = 8'd10;
    localparam logic [4:0] HEX_RADIX = 5'd16;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CHECK   = 2'd2;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_BAD_FORMAT = 3'd1;
    localparam logic [2:0] STATUS_MISMATCH   = 3'd2;
    localparam logic [2:0] STATUS_UNKNOWN    = 3'd3;
    localparam logic [2:0] STATUS_OVERFLOW   = 3'd4;

    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_ERROR = 3'd6;

    localparam int NUM_TYPES = 5;

    localparam logic [23:0] TYPE_CODES [NUM_TYPES] = '{
        24'h434841, 24'h414343, 24'h524556, 24'h53484F, 24'h524553
    };
    localparam logic [1:0] TYPE_FIELDS [NUM_TYPES] = '{
        2'd1, 2'd1, 2'd1, 2'd2, 2'd3
    };

    typedef struct packed {
        logic [1:0]  phase;
        logic [7:0]  frame_length;
        logic [7:0]  running_xor;
        logic [23:0] type_letters;
        logic [2:0]  type_letter_count;
        logic [1:0]  field_index;
        logic [7:0]  field_value_a;
        logic [7:0]  field_value_b;
        logic [7:0]  field_value_c;
        logic        digits_ended;
        logic [7:0]  check_value;
        logic [1:0]  check_digit_count;
        logic        check_bad_char;
    } frame_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] event_kind;
        logic [7:0] value_a;
        logic [7:0] value_b;
        logic [7:0] value_c;
    } result_t;

endpackage

>>> src/asdx_parser.sv
// Frame state tracker that folds one received byte per transaction into the sentence state.
module asdx_parser import asdx_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output frame_t     frame,
    output logic       emit
);

    frame_t frame_reg;
    frame_t frame_next;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
            return {1'b1, d[3:0]};
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            d = c - CHAR_UPPER_A + DEC_RADIX;
            return {1'b1, d[3:0]};
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            d = c - CHAR_LOWER_A + DEC_RADIX;
            return {1'b1, d[3:0]};
        end
        return {1'b0, d[3:0]};
    endfunction

    always_comb begin
        logic [4:0] hex;
        logic [7:0] digit;
        hex = hex_decode(rx_byte);
        digit = rx_byte - CHAR_ZERO;
        frame_next = frame_reg;
        emit = 1'b0;
        if (step) begin
            if (rx_byte == CHAR_DOLLAR) begin
                frame_next = '0;
                frame_next.phase = PH_PAYLOAD;
            end else if (frame_reg.phase == PH_IDLE) begin
                frame_next = frame_reg;
            end else if (rx_byte == CHAR_NEWLINE) begin
                emit = 1'b1;
                frame_next = '0;
            end else begin
                if (frame_reg.frame_length < FRAME_MAX) begin
                    frame_next.frame_length = frame_reg.frame_length + 8'd1;
                end
                if (frame_reg.phase == PH_PAYLOAD) begin
                    if (rx_byte == CHAR_STAR) begin
                        frame_next.phase = PH_CHECK;
                    end else begin
                        frame_next.running_xor = frame_reg.running_xor ^ rx_byte;
                        if (rx_byte == CHAR_COMMA) begin
                            if (frame_reg.field_index < 2'd3) begin
                                frame_next.field_index = frame_reg.field_index + 2'd1;
                                frame_next.digits_ended = 1'b0;
                            end else begin
                                frame_next.digits_ended = 1'b1;
                            end
                        end else if (frame_reg.field_index == 2'd0) begin
                            if (frame_reg.type_letter_count < 3'd3) begin
                                frame_next.type_letters = {frame_reg.type_letters[15:0], rx_byte};
                            end
                            if (frame_reg.type_letter_count < 3'd4) begin
                                frame_next.type_letter_count =
                                    frame_reg.type_letter_count + 3'd1;
                            end
                        end else if (!frame_reg.digits_ended) begin
                            if (rx_byte >= CHAR_ZERO && rx_byte <= CHAR_NINE) begin
                                case (frame_reg.field_index)
                                    2'd1: frame_next.field_value_a =
                                        frame_reg.field_value_a * DEC_RADIX + digit;
                                    2'd2: frame_next.field_value_b =
                                        frame_reg.field_value_b * DEC_RADIX + digit;
                                    2'd3: frame_next.field_value_c =
                                        frame_reg.field_value_c * DEC_RADIX + digit;
                                    default: frame_next.field_value_a = frame_reg.field_value_a;
                                endcase
                            end else begin
                                frame_next.digits_ended = 1'b1;
                            end
                        end
                    end
                end else begin
                    if (!hex[4]) begin
                        frame_next.check_bad_char = 1'b1;
                    end else if (frame_reg.check_digit_count < 2'd2) begin
                        frame_next.check_value = {frame_reg.check_value[3:0], hex[3:0]};
                    end
                    if (frame_reg.check_digit_count < 2'd3) begin
                        frame_next.check_digit_count = frame_reg.check_digit_count + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= '0;
        end else begin
            frame_reg <= frame_next;
        end
    end

    assign frame = frame_reg;

endmodule

>>> src/asdx_finish.sv
// Result evaluation that turns the state of an ended frame into status, kind and values.
module asdx_finish import asdx_pkg::*; (
    input  frame_t  frame,
    output result_t result
);

    always_comb begin
        logic [2:0] t;
        logic       known;
        t = 3'd0;
        known = 1'b0;
        for (int i = NUM_TYPES - 1; i >= 0; i--) begin
            if (frame.type_letter_count == 3'd3 && frame.type_letters == TYPE_CODES[i]) begin
                t = 3'(i);
                known = 1'b1;
            end
        end
        result = '0;
        if (frame.frame_length >= FRAME_MAX) begin
            result.status = STATUS_OVERFLOW;
            result.event_kind = KIND_ERROR;
        end else if (frame.phase != PH_CHECK || frame.check_digit_count != 2'd2
                     || frame.check_bad_char) begin
            result.status = STATUS_BAD_FORMAT;
            result.event_kind = KIND_ERROR;
        end else if (frame.check_value != frame.running_xor) begin
            result.status = STATUS_MISMATCH;
            result.event_kind = KIND_ERROR;
        end else if (!known) begin
            result.status = STATUS_UNKNOWN;
            result.event_kind = KIND_NONE;
        end else begin
            result.status = STATUS_OK;
            result.event_kind = t + 3'd1;
            result.value_a = frame.field_value_a;
            if (TYPE_FIELDS[t] >= 2'd2) begin
                result.value_b = frame.field_value_b;
            end
            if (TYPE_FIELDS[t] >= 2'd3) begin
                result.value_c = frame.field_value_c;
            end
        end
    end

endmodule

>>> src/ascii_sentence_decoder_xor_check_top.sv
// Top level of the sentence decoder: input register, frame parser and result register.
//
// The block takes one received byte per transaction and decodes sentences of the form
// "$TYPE,n,n,n*HH" ended by a newline, checking the XOR checksum over the payload. A byte
// accepted into the input register waits there until it can advance; the edge at which it
// advances updates the frame state and, for a newline that ends a frame, loads the result
// register, from which the result is offered. A new byte is accepted every
// cycle while results are taken; the input register holds its byte whenever a result waits
// unaccepted in the result register, so a held-off result stalls the input after one more
// byte.
module ascii_sentence_decoder_xor_check_top import asdx_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [2:0] m_event_kind,
    output logic [7:0] m_value_a,
    output logic [7:0] m_value_b,
    output logic [7:0] m_value_c
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    logic       advance;
    logic       emit;
    frame_t     frame;
    result_t    result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    asdx_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .frame   (frame),
        .emit    (emit)
    );

    asdx_finish u_finish (
        .frame  (frame),
        .result (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance && emit) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_status = out_reg.status;
    assign m_event_kind = out_reg.event_kind;
    assign m_value_a = out_reg.value_a;
    assign m_value_b = out_reg.value_b;
    assign m_value_c = out_reg.value_c;

endmodule
